// ===== rtl/lru_page_cache_lookup_assert.svh =====
// Assertion macros for the LRU page cache lookup.
// Depends on nothing; expects clk and rst_n in the including scope.
`ifndef LRU_PAGE_CACHE_LOOKUP_ASSERT_SVH
`define LRU_PAGE_CACHE_LOOKUP_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define LPLC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define LPLC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lplc_pkg.sv =====
// Shared types and constants for the LRU page cache lookup.
// No dependencies.
package lplc_pkg;

  localparam int PAGE_W   = 52;  // page number width
  localparam int SLOT_FW  = 6;   // slot field width on the result
  localparam int IN_TDW   = 56;  // page_id padded to bytes
  localparam int OUT_TDW  = 64;  // 60 bits of result padded to bytes

  // Tag compare outcome handed from the tag store to the top level
  typedef struct packed {
    logic               hit;
    logic [SLOT_FW-1:0] slot;
  } lplc_match_t;

  // One result item
  typedef struct packed {
    logic [PAGE_W-1:0]  evicted_page;
    logic               evicted_valid;
    logic [SLOT_FW-1:0] slot;
    logic               hit;
  } lplc_result_t;

endpackage

// ===== rtl/lplc_tag_store.sv =====
// Tag and valid storage with a parallel tag compare across all slots.
// Depends on lplc_pkg.
module lplc_tag_store
  import lplc_pkg::*;
#(
  parameter int WAYS   = 16,
  parameter int SLOT_W = $clog2(WAYS)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [PAGE_W-1:0] lookup_page,
  input  logic [SLOT_W-1:0] lru_slot,
  input  logic              wr_en,
  output lplc_match_t       match,
  output logic              victim_valid,
  output logic [PAGE_W-1:0] victim_page
);

  logic [PAGE_W-1:0] tag_r [WAYS];
  logic [WAYS-1:0]   valid_r;
  logic [WAYS-1:0]   hit_vec;

  // Compare every valid slot, then OR-encode the (at most one) match
  always_comb begin
    match = '0;
    for (int i = 0; i < WAYS; i++) begin
      hit_vec[i] = valid_r[i] && (tag_r[i] == lookup_page);
      if (hit_vec[i]) begin
        match.slot = match.slot | SLOT_FW'(i);
      end
    end
    match.hit = |hit_vec;
  end

  // Page held by the least recent slot, zero when that slot is empty
  assign victim_valid = valid_r[lru_slot];
  assign victim_page  = victim_valid ? tag_r[lru_slot] : '0;

  // Valid bits clear at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[lru_slot] <= 1'b1;
    end
  end

  // Tags are only read behind a valid bit, so no reset
  always_ff @(posedge clk) begin
    if (wr_en) begin
      tag_r[lru_slot] <= lookup_page;
    end
  end

endmodule

// ===== rtl/lplc_recency.sv =====
// Recency list of slot numbers, least recent first, with move-to-most-recent.
// Depends on lplc_pkg.
module lplc_recency
  import lplc_pkg::*;
#(
  parameter int WAYS   = 16,
  parameter int SLOT_W = $clog2(WAYS)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              touch_en,
  input  logic [SLOT_W-1:0] touch_slot,
  output logic [SLOT_W-1:0] lru_slot
);

  logic [SLOT_W-1:0] order_r   [WAYS];
  logic [SLOT_W-1:0] order_nxt [WAYS];
  logic [WAYS-1:0]   at_pos;
  logic [WAYS-1:0]   shift;

  assign lru_slot = order_r[0];

  // Locate the touched slot; every entry above it moves down one place
  always_comb begin
    for (int j = 0; j < WAYS; j++) begin
      at_pos[j] = (order_r[j] == touch_slot);
    end
    for (int j = 0; j < WAYS; j++) begin
      shift[j] = 1'b0;
      for (int k = 0; k <= j; k++) begin
        shift[j] = shift[j] | at_pos[k];
      end
    end
    for (int j = 0; j < WAYS - 1; j++) begin
      order_nxt[j] = shift[j] ? order_r[j + 1] : order_r[j];
    end
    order_nxt[WAYS - 1] = touch_slot;
  end

  // Ascending order out of reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < WAYS; j++) begin
        order_r[j] <= SLOT_W'(j);
      end
    end else if (touch_en) begin
      order_r <= order_nxt;
    end
  end

endmodule

// ===== rtl/lru_page_cache_lookup.sv =====
// LRU page cache lookup: one page request per cycle while out_tready is high;
// an accepted request goes to the input register, then the result register.
// The tag compare across all WAYS slots and the recency list update are
// combinational between those registers, so back-to-back requests see each
// other's updates with no stall. A full result register stalls the input only
// when out_tready is low. No clearing pass after reset: valid bits clear at once.
// Depends on lplc_pkg, lplc_tag_store, lplc_recency and the assertion header.
`include "lru_page_cache_lookup_assert.svh"

module lru_page_cache_lookup
  import lplc_pkg::*;
#(
  parameter int WAYS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [IN_TDW-1:0]  in_tdata,   // [51:0] page_id, [55:52] zero
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [OUT_TDW-1:0] out_tdata   // [0] hit, [6:1] slot,
                                         // [7] evicted_valid,
                                         // [59:8] evicted_page, [63:60] zero
);

  localparam int SLOT_W = $clog2(WAYS);

  logic              in_valid_r;
  logic [PAGE_W-1:0] page_r;
  logic              out_valid_r;
  lplc_result_t      result_r;
  lplc_result_t      result_nxt;

  logic              adv;
  logic              fire;
  lplc_match_t       match;
  logic [SLOT_W-1:0] lru_slot;
  logic [SLOT_W-1:0] touch_slot;
  logic              victim_valid;
  logic [PAGE_W-1:0] victim_page;

  // Handshake: result register frees when empty or being taken
  assign adv       = !out_valid_r || out_tready;
  assign in_tready = !in_valid_r || adv;
  assign fire      = in_valid_r && adv;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDW'(result_r);

  lplc_tag_store #(
    .WAYS   (WAYS),
    .SLOT_W (SLOT_W)
  ) u_tags (
    .clk          (clk),
    .rst_n        (rst_n),
    .lookup_page  (page_r),
    .lru_slot     (lru_slot),
    .wr_en        (fire && !match.hit),
    .match        (match),
    .victim_valid (victim_valid),
    .victim_page  (victim_page)
  );

  lplc_recency #(
    .WAYS   (WAYS),
    .SLOT_W (SLOT_W)
  ) u_recency (
    .clk        (clk),
    .rst_n      (rst_n),
    .touch_en   (fire),
    .touch_slot (touch_slot),
    .lru_slot   (lru_slot)
  );

  // Hit touches the matching slot; miss refills and touches the LRU slot
  assign touch_slot = match.hit ? match.slot[SLOT_W-1:0] : lru_slot;

  always_comb begin
    result_nxt.hit = match.hit;
    if (match.hit) begin
      result_nxt.slot          = match.slot;
      result_nxt.evicted_valid = 1'b0;
      result_nxt.evicted_page  = '0;
    end else begin
      result_nxt.slot          = SLOT_FW'(lru_slot);
      result_nxt.evicted_valid = victim_valid;
      result_nxt.evicted_page  = victim_page;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (adv) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      page_r <= in_tdata[PAGE_W-1:0];
    end
    if (fire) begin
      result_r <= result_nxt;
    end
  end

  // Checks
  `LPLC_ASSERT_NXT(a_fire_gives_result, fire, out_valid_r,
    "lookup did not load the result register")
  `LPLC_ASSERT_IMP(a_hit_no_evict, out_valid_r && result_r.hit,
    !result_r.evicted_valid && (result_r.evicted_page == '0),
    "hit reported an eviction")
  `LPLC_ASSERT_IMP(a_slot_range, out_valid_r, int'(result_r.slot) < WAYS,
    "result slot out of range")

endmodule
